>>> design/assert_macros.svh
// Assertion macros used by the checker file of the gradient magnitude block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

>>> design/pgm_pkg.sv
// Types and constants shared by the gradient magnitude modules.
`timescale 1ns / 1ps

package pgm_pkg;

    localparam int PIX_W             = 8;
    localparam int CFG_W             = 12;
    localparam int CFG_IDX_W         = 2;
    localparam int COORD_W           = 11;
    localparam int MAG_W             = 12;
    localparam int DIFF_W            = 9;
    localparam int SQ_W              = 16;
    localparam int SQRT_SHIFT        = 7;
    localparam int RAD_W             = SQ_W + 1 + SQRT_SHIFT;
    localparam int REM_W             = 13;
    localparam int DIGITS_PER_STAGE  = 2;
    localparam int SQRT_STAGES       = MAG_W / DIGITS_PER_STAGE;

    localparam logic [MAG_W-1:0] MAG_MAX = 12'd4080;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Coordinates that travel alongside the data
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } side_t;

    // Line buffer stage output
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] right;
        logic             zero;
        side_t            side;
    } front_t;

    // Square root pipeline state
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
        side_t            side;
    } sqrt_t;

endpackage

>>> design/pgm_front.sv
// Raster counters and previous-row line buffer feeding the arithmetic pipeline.
`timescale 1ns / 1ps

module pgm_front import pgm_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] frame_width,
    input  logic [CFG_W-1:0] frame_height,
    input  logic             s_valid,
    input  logic [PIX_W-1:0] s_pixel,
    output logic             s_ready,
    output logic             m_valid,
    output front_t           m_data,
    input  logic             m_ready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [AW-1:0] col_reg, col_next, col_p1;
    logic [RW-1:0] row_reg, row_next;
    logic          valid_reg;
    front_t        data_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          last_col, last_row, accept;

    // Clamp the frame size to the supported range
    always_comb begin
        if (frame_width < CFG_W'(2)) begin
            w_eff = WW'(2);
        end else if (32'(frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width);
        end
        if (frame_height < CFG_W'(2)) begin
            h_eff = HW'(2);
        end else if (32'(frame_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(frame_height);
        end
    end

    // Row and frame end; counters at or past the end also wrap
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(h_eff);
    assign col_p1   = col_reg + 1'b1;

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_p1;
            row_next = row_reg;
        end
    end

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Control state: counters and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                // row zero only fills the line buffer
                valid_reg <= accept && (row_reg != '0);
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Line buffer: read old row at col and col+1, then overwrite col
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            data_reg.centre         <= line_mem[col_reg];
            data_reg.right          <= line_mem[col_p1];
            data_reg.pixel          <= s_pixel;
            data_reg.zero           <= last_col;
            data_reg.side.row       <= COORD_W'(row_reg) - COORD_W'(1);
            data_reg.side.col       <= COORD_W'(col_reg);
            data_reg.side.frame_end <= last_col && last_row;
        end
        if (accept) begin
            line_mem[col_reg] <= s_pixel;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> design/pgm_square.sv
// Differences, squares and scaled sum of squares: three pipeline stages.
`timescale 1ns / 1ps

module pgm_square import pgm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  front_t s_data,
    output logic   s_ready,
    output logic   m_valid,
    output sqrt_t  m_data,
    input  logic   m_ready
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic signed [DIFF_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [2*DIFF_W-1:0] px, py;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic [SQ_W:0]              sum;
    side_t                      side1_reg, side2_reg;
    sqrt_t                      out_reg;

    // Ready chain: a stage moves when it is empty or the next one moves
    assign r3 = !v3_reg || m_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // Forward differences; the last column gives zero
    always_comb begin
        if (s_data.zero) begin
            dx_next = '0;
            dy_next = '0;
        end else begin
            dx_next = DIFF_W'(s_data.right) - DIFF_W'(s_data.centre);
            dy_next = DIFF_W'(s_data.pixel) - DIFF_W'(s_data.centre);
        end
    end

    assign px  = dx_reg * dx_reg;
    assign py  = dy_reg * dy_reg;
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (r1) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= s_data.side;
        end
        if (r2) begin
            sqx_reg   <= px[SQ_W-1:0];
            sqy_reg   <= py[SQ_W-1:0];
            side2_reg <= side1_reg;
        end
        if (r3) begin
            // radicand is the sum times 128
            out_reg.rad  <= {sum, {SQRT_SHIFT{1'b0}}};
            out_reg.rem  <= '0;
            out_reg.root <= '0;
            out_reg.side <= side2_reg;
        end
    end

    assign m_valid = v3_reg;
    assign m_data  = out_reg;

endmodule

>>> design/pgm_sqrt_step.sv
// One square root pipeline stage: two result bits, digit-by-digit restoring method.
`timescale 1ns / 1ps

module pgm_sqrt_step import pgm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  sqrt_t s_data,
    output logic  s_ready,
    output logic  m_valid,
    output sqrt_t m_data,
    input  logic  m_ready
);

    logic              valid_reg;
    sqrt_t             data_reg, step_next;
    logic [REM_W+1:0]  cur, trial;

    // Each digit: bring down two radicand bits, try root*4+1
    always_comb begin
        step_next = s_data;
        cur       = '0;
        trial     = '0;
        for (int k = 0; k < DIGITS_PER_STAGE; k++) begin
            cur            = {step_next.rem, step_next.rad[RAD_W-1 -: 2]};
            trial          = {1'b0, step_next.root, 2'b01};
            step_next.rad  = {step_next.rad[RAD_W-3:0], 2'b00};
            if (cur >= trial) begin
                step_next.rem  = REM_W'(cur - trial);
                step_next.root = {step_next.root[MAG_W-2:0], 1'b1};
            end else begin
                step_next.rem  = cur[REM_W-1:0];
                step_next.root = {step_next.root[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            data_reg <= step_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> design/pixel_gradient_magnitude_top.sv
// Top level of the streaming forward-difference gradient magnitude block.
//
// Usage:
//   Input channel s_*: one 8-bit grey pixel per item, raster order.
//   Result channel m_*: one item per pixel of rows 1 and up, giving the
//   magnitude of the pixel one row above times sqrt(2) (unsigned Q9.3), its row and
//   column, and frame_end on the last result of a frame. Row 0 pixels
//   produce no result; the last row of a frame is never reported.
//   Config channel cfg_*: index 0 frame_width, index 1 frame_height; write
//   only while the block is idle. cfg_ready is always high.
// Pipeline:
//   m_valid rises once an accepted pixel has passed 1 line buffer stage,
//   3 difference/square/sum stages and 6 square root stages of two bits.
//   Throughput is one item per cycle while m_ready is high, set by the
//   single-port-write line buffer and the fully pipelined square root.
// Reset clears counters, stage valids and restores 640x480; the line
//   buffer is not cleared. When m_ready is low, results hold and the
//   pipeline keeps filling its empty stages; s_ready drops once all are full.
`timescale 1ns / 1ps

module pixel_gradient_magnitude_top import pgm_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MAG_W-1:0]     m_magnitude,
    output logic [COORD_W-1:0]   m_out_row,
    output logic [COORD_W-1:0]   m_out_col,
    output logic                 m_frame_end
);

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;

    logic   front_valid, front_ready;
    front_t front_data;

    logic  sq_valid [SQRT_STAGES+1];
    logic  sq_ready [SQRT_STAGES+1];
    sqrt_t sq_data  [SQRT_STAGES+1];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Line buffer and counters
    pgm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .s_valid      (s_valid),
        .s_pixel      (s_pixel),
        .s_ready      (s_ready),
        .m_valid      (front_valid),
        .m_data       (front_data),
        .m_ready      (front_ready)
    );

    // Differences and sum of squares
    pgm_square u_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (front_valid),
        .s_data  (front_data),
        .s_ready (front_ready),
        .m_valid (sq_valid[0]),
        .m_data  (sq_data[0]),
        .m_ready (sq_ready[0])
    );

    // Square root pipeline
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
        pgm_sqrt_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (sq_valid[i]),
            .s_data  (sq_data[i]),
            .s_ready (sq_ready[i]),
            .m_valid (sq_valid[i+1]),
            .m_data  (sq_data[i+1]),
            .m_ready (sq_ready[i+1])
        );
    end

    // Result channel
    assign sq_ready[SQRT_STAGES] = m_ready;
    assign m_valid     = sq_valid[SQRT_STAGES];
    assign m_magnitude = sq_data[SQRT_STAGES].root;
    assign m_out_row   = sq_data[SQRT_STAGES].side.row;
    assign m_out_col   = sq_data[SQRT_STAGES].side.col;
    assign m_frame_end = sq_data[SQRT_STAGES].side.frame_end;

endmodule

>>> design/pgm_checker.sv
// Port-level assertions for the gradient magnitude block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pgm_checker import pgm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_ready,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [MAG_W-1:0]     m_magnitude,
    input logic [COORD_W-1:0]   m_out_row,
    input logic [COORD_W-1:0]   m_out_col,
    input logic                 m_frame_end
);

    logic [MAG_W+2*COORD_W:0] m_payload;

    // All result fields side by side
    assign m_payload = {m_magnitude, m_out_row, m_out_col, m_frame_end};

    // A stalled result holds
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // Magnitude never exceeds the Q9.3 maximum
    `ASSERT_IMPLY(a_mag_range, aclk, aresetn, m_valid, m_magnitude <= MAG_MAX)

    // With the output stage empty the whole pipeline can move
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready && cfg_ready)

    // Reset empties the pipeline
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind pixel_gradient_magnitude_top pgm_checker u_pgm_checker (.*);

>>> tb/sv/pixel_gradient_magnitude_top_tb.sv
// Self-checking testbench for the streaming gradient magnitude block.
`timescale 1ns / 1ps

module pixel_gradient_magnitude_top_tb;
    import pgm_pkg::*;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int DRAIN_GAP     = 16;     // pipeline latency plus margin
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // cycles without any accepted item
    localparam int RANDOM_ITEMS  = 60;
    localparam int IDLE_PERCENT  = 8;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Pixel patterns for generated items
    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_NEAR_FLAT
    } pix_mode_t;

    typedef struct {
        logic [MAG_W-1:0]   magnitude;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } grad_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [MAG_W-1:0]     m_magnitude;
    logic [COORD_W-1:0]   m_out_row;
    logic [COORD_W-1:0]   m_out_col;
    logic                 m_frame_end;

    // Predictor state
    logic [CFG_W-1:0]     cfg_width  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]     cfg_height = FRAME_HEIGHT_RST;
    logic [PIX_W-1:0]     prev_row_pix [MAX_WIDTH];
    int                   col_pos = 0;
    int                   row_pos = 0;
    grad_result_t         pending_grads [$];

    int                   mismatch_count = 0;
    int                   stall_cycles   = 0;
    bit                   no_idle        = 1'b0;
    int                   hold_asks      = 0;
    int                   hold_done      = 0;
    int                   hold_left      = 0;

    pixel_gradient_magnitude_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_frame_end (m_frame_end)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Floor of the square root, bit by bit from the top
    function automatic logic [MAG_W-1:0] root_floor(input int v);
        int r;
        int t;
        r = 0;
        for (int b = 13; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= v)
                r = t;
        end
        return r[MAG_W-1:0];
    endfunction

    // Gradient of the pixel one row up, then advance the raster position
    function automatic void compute_gradient(input logic [PIX_W-1:0] px);
        int eff_w;
        int eff_h;
        int col;
        int row;
        int pix_v;
        int centre;
        int right;
        int dx;
        int dy;
        bit last_col;
        bit last_row;
        grad_result_t res;
        eff_w    = clamp_dim(cfg_width, MAX_WIDTH);
        eff_h    = clamp_dim(cfg_height, MAX_HEIGHT);
        col      = col_pos;
        row      = row_pos;
        pix_v    = px;
        last_col = (col >= eff_w - 1);
        last_row = (row >= eff_h - 1);
        if (row >= 1) begin
            res.magnitude = '0;
            // no right neighbour on the last column
            if (!last_col && col + 1 < MAX_WIDTH) begin
                centre = prev_row_pix[col];
                right  = prev_row_pix[col + 1];
                dx     = right - centre;
                dy     = pix_v - centre;
                res.magnitude = root_floor((dx * dx + dy * dy) * 128);
            end
            res.row       = COORD_W'(row - 1);
            res.col       = COORD_W'(col);
            res.frame_end = last_col && last_row;
            pending_grads = {pending_grads, res};
        end
        if (col < MAX_WIDTH)
            prev_row_pix[col] = px;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_t mode);
        case (mode)
            PIX_EXTREME:   return $urandom_range(1) ? 8'd255 : 8'd0;
            PIX_NEAR_FLAT: return PIX_W'($urandom_range(140, 116));
            default:       return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Offer one item, with random gaps before it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        compute_gradient(px);
    endtask

    task automatic send_pixels(input int count, input pix_mode_t mode);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(mode));
    endtask

    // Stop offering and let every expected result come out
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = data;
            REG_FRAME_HEIGHT: cfg_height = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Reset geometry, then shrink height and width in the middle of a frame
    task automatic test_reset_geometry();
        send_pixels(642, PIX_UNIFORM);
        wait_results_drained();
        write_reg(REG_FRAME_HEIGHT, 12'd2);
        send_pixels(1, PIX_UNIFORM);
        wait_results_drained();
        write_reg(REG_FRAME_WIDTH, 12'd2);
        send_pixels(1, PIX_UNIFORM);
        wait_results_drained();
    endtask

    // Full-scale positive and negative differences, last column, flat image
    task automatic test_extremes();
        logic [PIX_W-1:0] steep [6] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
        set_frame(12'd2, 12'd3);
        foreach (steep[i])
            send_pixel(steep[i]);
        wait_results_drained();
        set_frame(12'd3, 12'd2);
        for (int i = 0; i < 6; i++)
            send_pixel(8'd77);
        wait_results_drained();
    endtask

    // Writes to unused indexes must leave the geometry alone
    task automatic test_unused_index();
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'h000);
        send_pixels(6, PIX_EXTREME);
        wait_results_drained();
    endtask

    // Out-of-range registers clamp to the legal sizes
    task automatic test_clamping();
        // oversized width keeps the row open, height 1 acts as two rows
        set_frame(12'hFFF, 12'd1);
        send_pixels(24, PIX_UNIFORM);
        wait_results_drained();
        // width 0 acts as two: the row ends at once, then one result row
        write_reg(REG_FRAME_WIDTH, 12'd0);
        send_pixels(3, PIX_UNIFORM);
        wait_results_drained();
        // oversized height: no frame end over many short rows
        write_reg(REG_FRAME_HEIGHT, 12'hFFF);
        send_pixels(40, PIX_UNIFORM);
        wait_results_drained();
        // height 0 acts as two: the current row becomes the last
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        send_pixels(2, PIX_UNIFORM);
        wait_results_drained();
        set_frame(12'd1, 12'd0);
        send_pixels(4, PIX_EXTREME);
        wait_results_drained();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_frame(12'd8, 12'd8);
        hold_asks++;
        send_pixels(48, PIX_UNIFORM);
        wait_results_drained();
    endtask

    // Back-to-back items with no gaps on either side
    task automatic test_streaming();
        set_frame(12'd16, 12'd6);
        no_idle = 1'b1;
        send_pixels(64, PIX_UNIFORM);
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    // Random geometries, changed at random points in the frame
    task automatic test_random_frames();
        int sent;
        int n;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        pix_mode_t mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(4095))
                                         : CFG_W'($urandom_range(24, 0));
            h = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(4095))
                                         : CFG_W'($urandom_range(9, 0));
            wait_results_drained();
            case ($urandom_range(2))
                0:       write_reg(REG_FRAME_WIDTH, w);
                1:       write_reg(REG_FRAME_HEIGHT, h);
                default: set_frame(w, h);
            endcase
            n    = $urandom_range(80, 10);
            mode = pix_mode_t'($urandom_range(2));
            send_pixels(n, mode);
            sent += n;
        end
        wait_results_drained();
    endtask

    // Result side: random stalls and a counted hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_done) begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        grad_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_grads.size() == 0) begin
                report_mismatch("unexpected item, magnitude", m_magnitude, 0);
            end else begin
                want = pending_grads.pop_front();
                if (m_magnitude !== want.magnitude)
                    report_mismatch("magnitude", m_magnitude, want.magnitude);
                if (m_out_row !== want.row)
                    report_mismatch("out_row", m_out_row, want.row);
                if (m_out_col !== want.col)
                    report_mismatch("out_col", m_out_col, want.col);
                if (m_frame_end !== want.frame_end)
                    report_mismatch("frame_end", m_frame_end, want.frame_end);
            end
        end
    end

    // Watchdog on cycles with no accepted item anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry();
        test_extremes();
        test_unused_index();
        test_clamping();
        test_backpressure();
        test_streaming();
        test_random_frames();
        wait_results_drained();
        if (pending_grads.size() != 0)
            report_mismatch("items left over", pending_grads.size(), 0);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/pgm_pkg.sv
design/pgm_front.sv
design/pgm_square.sv
design/pgm_sqrt_step.sv
design/pixel_gradient_magnitude_top.sv
design/pgm_checker.sv
tb/sv/pixel_gradient_magnitude_top_tb.sv
